### rtl/dstwr_pkg.sv
package dstwr_pkg;

    localparam int unsigned TS_W   = 32;
    localparam int unsigned TOF_W  = 33;
    localparam int unsigned DIST_W = 20;
    localparam int unsigned ADLY_W = 16;
    localparam int unsigned SCL_W  = 20;
    localparam int unsigned FRAC_W = 16;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_POS = 2'd1;
    localparam logic [1:0] ST_DIV_0   = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    localparam logic REG_ANT_DELAY = 1'b0;
    localparam logic REG_MM_SCALE  = 1'b1;

    localparam logic [ADLY_W-1:0] ANT_DELAY_RST = 16'd16450;
    localparam logic [SCL_W-1:0]  MM_SCALE_RST  = 20'd307387;

    typedef struct packed {
        logic [TS_W-1:0] poll_sent;
        logic [TS_W-1:0] answer_received;
        logic [TS_W-1:0] final_sent;
        logic [TS_W-1:0] remote_poll_received;
        logic [TS_W-1:0] remote_answer_sent;
        logic [TS_W-1:0] remote_final_received;
    } t_in_item;

    typedef struct packed {
        logic signed [TOF_W-1:0] flight_ticks;
        logic [DIST_W-1:0]       distance_mm;
        logic [1:0]              status;
    } t_out_item;

    // Per-item flags that ride along with the divider.
    typedef struct packed {
        logic neg;
        logic den_zero;
    } t_side;

endpackage

### rtl/dstwr_div.sv
module dstwr_div
    import dstwr_pkg::*;
#(
    parameter int unsigned QW = 64,
    parameter int unsigned DW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output t_side         o_side
);

    // One quotient bit per stage, restoring division.
    logic          r_valid [QW];
    logic [QW-1:0] r_num   [QW];
    logic [QW-1:0] r_quot  [QW];
    logic [DW-1:0] r_rem   [QW];
    logic [DW-1:0] r_den   [QW];
    t_side         r_side  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic          p_valid;
        logic [QW-1:0] p_num;
        logic [QW-1:0] p_quot;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        t_side         p_side;
        logic [DW:0]   trial;
        logic          take;
        logic [DW:0]   diff;

        if (g == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_num   = i_num;
            assign p_quot  = '0;
            assign p_rem   = '0;
            assign p_den   = i_den;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[g-1];
            assign p_num   = r_num[g-1];
            assign p_quot  = r_quot[g-1];
            assign p_rem   = r_rem[g-1];
            assign p_den   = r_den[g-1];
            assign p_side  = r_side[g-1];
        end

        assign trial = {p_rem, p_num[QW-1]};
        assign take  = (trial >= {1'b0, p_den});
        assign diff  = trial - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g]  <= {p_num[QW-2:0], 1'b0};
                r_quot[g] <= {p_quot[QW-2:0], take};
                r_rem[g]  <= take ? diff[DW-1:0] : trial[DW-1:0];
                r_den[g]  <= p_den;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

### rtl/ds_twr_range_compute_core.sv
// Double-sided two-way ranging core. Each accepted transfer carries six
// timestamps and yields exactly one result: time of flight in ticks, distance
// in millimetres and a status code. The core accepts one exchange per cycle
// while the output is not stalled and computes through a bit-per-stage divider
// pipeline. The pipeline moves as a whole, so a stalled output also stalls
// the input. Configuration writes are always ready and should only be made
// while no exchange is in flight.
module ds_twr_range_compute_core
    import dstwr_pkg::*;
#(
    parameter int unsigned STAMP_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [SCL_W-1:0]     i_cfg_data
);

    localparam int unsigned SB = STAMP_BITS;
    localparam int unsigned QW = 2 * SB;
    localparam int unsigned DW = SB + 2;
    localparam int unsigned QX = (QW > 45) ? QW : 45;
    localparam int unsigned PW = 44 + SCL_W;

    logic [ADLY_W-1:0] r_ant;
    logic [SCL_W-1:0]  r_scale;
    logic              en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ant   <= ANT_DELAY_RST;
            r_scale <= MM_SCALE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ANT_DELAY: r_ant   <= i_cfg_data[ADLY_W-1:0];
                REG_MM_SCALE:  r_scale <= i_cfg_data;
                default:       r_ant   <= r_ant;
            endcase
        end
    end

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Stage 1: stamps with antenna delay applied.
    logic [SB+TS_W-1:0] x_pt, x_ar, x_ft, x_rp, x_ra, x_rf;
    logic [SB-1:0]      dly;
    assign x_pt = {{SB{1'b0}}, i_in_data.poll_sent};
    assign x_ar = {{SB{1'b0}}, i_in_data.answer_received};
    assign x_ft = {{SB{1'b0}}, i_in_data.final_sent};
    assign x_rp = {{SB{1'b0}}, i_in_data.remote_poll_received};
    assign x_ra = {{SB{1'b0}}, i_in_data.remote_answer_sent};
    assign x_rf = {{SB{1'b0}}, i_in_data.remote_final_received};
    assign dly  = SB'(r_ant);

    logic          r_v1;
    logic [SB-1:0] r_pt, r_ar, r_ft, r_rp, r_ra, r_rf;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt <= x_pt[SB-1:0] + dly;
            r_ar <= x_ar[SB-1:0] - dly;
            r_ft <= x_ft[SB-1:0] + dly;
            r_rp <= x_rp[SB-1:0];
            r_ra <= x_ra[SB-1:0];
            r_rf <= x_rf[SB-1:0];
        end
    end

    // Stage 2: wrapping differences.
    logic          r_v2;
    logic [SB-1:0] r_rnd1, r_rep1, r_rnd2, r_rep2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnd1 <= r_ar - r_pt;
            r_rep1 <= r_ra - r_rp;
            r_rnd2 <= r_rf - r_ra;
            r_rep2 <= r_ft - r_ar;
        end
    end

    // Stage 3: products and divisor.
    logic          r_v3;
    logic [QW-1:0] r_pa, r_pb;
    logic [DW-1:0] r_den3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa   <= QW'(r_rnd1) * QW'(r_rnd2);
            r_pb   <= QW'(r_rep1) * QW'(r_rep2);
            r_den3 <= DW'(r_rnd1) + DW'(r_rnd2) + DW'(r_rep1) + DW'(r_rep2);
        end
    end

    // Stage 4: signed difference as magnitude and sign.
    logic          r_v4;
    logic [QW-1:0] r_mag;
    logic [DW-1:0] r_den4;
    t_side         r_side4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag            <= (r_pa >= r_pb) ? (r_pa - r_pb) : (r_pb - r_pa);
            r_side4.neg      <= (r_pa < r_pb);
            r_side4.den_zero <= (r_den3 == '0);
            r_den4           <= (r_den3 == '0) ? DW'(1) : r_den3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    logic          dv_valid;
    logic [QW-1:0] dv_quot;
    t_side         dv_side;

    dstwr_div #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v4),
        .i_num   (r_mag),
        .i_den   (r_den4),
        .i_side  (r_side4),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    // Stage 5: saturation flags and scaling product.
    logic [QX-1:0] qx;
    assign qx = QX'(dv_quot);

    logic          r_v5;
    logic [31:0]   r_tof;
    logic          r_nonpos, r_dz, r_big, r_szero;
    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tof    <= (|qx[QX-1:32]) ? 32'hFFFF_FFFF : qx[31:0];
            r_nonpos <= dv_side.neg || (dv_quot == '0);
            r_dz     <= dv_side.den_zero;
            r_big    <= |qx[QX-1:44];
            r_szero  <= (r_scale == '0);
            r_prod   <= PW'(qx[43:0]) * PW'(r_scale);
        end
    end

    // Stage 6: output register.
    logic [PW-FRAC_W-1:0] dfull;
    assign dfull = r_prod[PW-1:FRAC_W];

    logic      r_v6;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v5 <= dv_valid;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dz) begin
                r_out.flight_ticks <= '0;
                r_out.distance_mm  <= '0;
                r_out.status       <= ST_DIV_0;
            end else if (r_nonpos) begin
                r_out.flight_ticks <= TOF_W'(0) - {1'b0, r_tof};
                r_out.distance_mm  <= '0;
                r_out.status       <= ST_NOT_POS;
            end else begin
                r_out.flight_ticks <= {1'b0, r_tof};
                if (r_szero) begin
                    r_out.distance_mm <= '0;
                    r_out.status      <= ST_OK;
                end else if (r_big || (|dfull[PW-FRAC_W-1:DIST_W])) begin
                    r_out.distance_mm <= '1;
                    r_out.status      <= ST_SAT;
                end else begin
                    r_out.distance_mm <= dfull[DIST_W-1:0];
                    r_out.status      <= ST_OK;
                end
            end
        end
    end

    assign o_out_valid = r_v6;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_DIV_0) |->
        (o_out_data.flight_ticks == '0 && o_out_data.distance_mm == '0))
        else $error("divisor-zero result carries nonzero fields");

    a_nonpos_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_NOT_POS) |->
        (o_out_data.distance_mm == '0 && !o_out_data.flight_ticks[TOF_W-1] == 1'b0
         || o_out_data.flight_ticks == '0))
        else $error("non-positive result has distance or positive flight");

    a_sat_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_SAT) |-> (o_out_data.distance_mm == '1))
        else $error("saturated result without full-scale distance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_v5)))
        else $error("pipeline moved during output stall");
`endif

endmodule
